FILE: src/rgbc_pkg.sv
// Shared types, constants and register indexes of the RGB convolution block.
package rgbc_pkg;

	localparam int CH_BITS       = 8;
	localparam int PIX_BITS      = 3 * CH_BITS;
	localparam int IMG_W_BITS    = 12;
	localparam int HALF_BITS     = 2;
	localparam int KROW_BITS     = 60;
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = KROW_BITS;
	localparam int KROWS         = 5;
	localparam int LINES         = 4;
	localparam int ROW_CNT_BITS  = 12;
	localparam int ROW_MAX       = 4095;
	localparam int COEF_FRAC     = 8;
	localparam int MAX_KERNEL    = 5;
	localparam int MAX_HALF      = (MAX_KERNEL - 1) / 2;
	localparam int MAX_WIDTH_DEF = 2048;
	localparam int COEF_BITS_DEF = 12;
	localparam int IMG_W_RESET   = 640;
	localparam int HALF_RESET    = 1;
	localparam int OFIFO_DEPTH   = 8;

	localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_WIDTH = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_HALF_WIDTH  = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_KROW0       = 3'd2;

	typedef struct packed {
		logic [CH_BITS-1:0] blue_in;
		logic [CH_BITS-1:0] green_in;
		logic [CH_BITS-1:0] red_in;
		logic               frame_start;
	} pix_t;

	typedef struct packed {
		logic [CH_BITS-1:0] blue_out;
		logic [CH_BITS-1:0] green_out;
		logic [CH_BITS-1:0] red_out;
		logic               position_valid;
		logic               is_border;
	} res_t;

endpackage

FILE: src/rgbc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rgbc_ram #(
	parameter int WIDTH = 96,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end

endmodule

FILE: src/rgbc_cell.sv
// Window cell: holds one pixel, passes it on, and forms three truncated products.
module rgbc_cell #(
	parameter int COEF_BITS = rgbc_pkg::COEF_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                shift_en,
	input  logic [rgbc_pkg::PIX_BITS-1:0]       pix_in,
	input  logic signed [COEF_BITS-1:0]         coef,
	input  logic                                use_coef,
	output logic [rgbc_pkg::PIX_BITS-1:0]       pix_q,
	output logic signed [COEF_BITS:0]           prod_s3 [3]
);

	localparam int XW = COEF_BITS + rgbc_pkg::CH_BITS + 1;

	logic signed [COEF_BITS-1:0]    k;
	logic [rgbc_pkg::PIX_BITS-1:0]  px;
	logic signed [XW-1:0]           x [3];
	logic signed [XW-1:0]           xr [3];

	assign k  = use_coef ? coef : '0;
	// unused taps may hold line data not yet written
	assign px = use_coef ? pix_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pix_q <= '0;
		else if (shift_en)
			pix_q <= pix_in;
	end

	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			x[ch] = XW'(k) * signed'({1'b0, px[ch*rgbc_pkg::CH_BITS +: rgbc_pkg::CH_BITS]});
			// round toward zero
			xr[ch] = x[ch] + (x[ch][XW-1] ? XW'((1 << rgbc_pkg::COEF_FRAC) - 1) : XW'(0));
		end
	end

	always_ff @(posedge clk) begin
		for (int ch = 0; ch < 3; ch++)
			prod_s3[ch] <= (COEF_BITS+1)'(xr[ch] >>> rgbc_pkg::COEF_FRAC);
	end

endmodule

FILE: src/rgbc_fifo.sv
// Small result queue decoupling the pipeline from the receiver.
module rgbc_fifo #(
	parameter int DEPTH = rgbc_pkg::OFIFO_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr,
	input  rgbc_pkg::res_t wdata,
	input  logic           rd,
	output rgbc_pkg::res_t rdata,
	output logic           not_empty,
	output logic [$clog2(DEPTH+1)-1:0] cnt_q
);

	localparam int PW = $clog2(DEPTH);

	rgbc_pkg::res_t  mem [DEPTH];
	logic [PW-1:0]   wp_q;
	logic [PW-1:0]   rp_q;

	assign not_empty = cnt_q != '0;
	assign rdata     = mem[rp_q];

	always_ff @(posedge clk) begin
		if (wr)
			mem[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr)
				wp_q <= (int'(wp_q) == DEPTH - 1) ? '0 : PW'(wp_q + 1'b1);
			if (rd)
				rp_q <= (int'(rp_q) == DEPTH - 1) ? '0 : PW'(rp_q + 1'b1);
			cnt_q <= cnt_q + (wr ? 1'b1 : 1'b0) - (rd ? 1'b1 : 1'b0);
		end
	end

endmodule

FILE: src/rgb_image_convolution.sv
// Top level of the streaming RGB convolution with a 1x1, 3x3 or 5x5 kernel.
// Usage:
//   pix/pix_valid/pix_ready carries one RGB pixel per transaction in raster
//   order; frame_start marks row 0, column 0. res/res_valid/res_ready carries
//   one result per pixel, for the centre at (row-d, col-d).
//   wr_en/wr_index/wr_data writes a register; write only while
//   no transaction is in flight.
//   A result goes through line read, window, products, row sums and queue.
//   Throughput: one pixel per cycle, set by the single line store port pair
//   (one read and one write per pixel) and the 5x5 grid of multiplier cells.
//   Results collect in an eight-entry queue; pix_ready drops only when eight
//   transactions are in flight, so a stalled receiver fills the queue first.
//   Reset clears counters, window cells, kernel and the queue; the line store
//   is not cleared and holds nothing useful until the first row has passed.
//   Width 0 acts as 1, width above MAX_WIDTH as MAX_WIDTH, half width 3 as 2.
module rgb_image_convolution #(
	parameter int MAX_WIDTH = rgbc_pkg::MAX_WIDTH_DEF,
	parameter int COEF_BITS = rgbc_pkg::COEF_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 pix_valid,
	output logic                                 pix_ready,
	input  rgbc_pkg::pix_t                       pix,
	output logic                                 res_valid,
	input  logic                                 res_ready,
	output rgbc_pkg::res_t                       res,
	input  logic                                 wr_en,
	input  logic [rgbc_pkg::CFG_IDX_BITS-1:0]    wr_index,
	input  logic [rgbc_pkg::CFG_DATA_BITS-1:0]   wr_data
);

	localparam int CW  = $clog2(MAX_WIDTH + 1);
	localparam int AW  = $clog2(MAX_WIDTH);
	localparam int PXB = rgbc_pkg::PIX_BITS;
	localparam int CHB = rgbc_pkg::CH_BITS;
	localparam int LW  = rgbc_pkg::LINES * PXB;
	localparam int KR  = rgbc_pkg::KROWS;
	localparam int PW  = COEF_BITS + 1;
	localparam int RW  = PW + 3;
	localparam int SW  = PW + 5;
	localparam int RB  = rgbc_pkg::ROW_CNT_BITS;
	localparam int FD  = rgbc_pkg::OFIFO_DEPTH;
	localparam int FCW = $clog2(FD + 1);

	// configuration
	logic [rgbc_pkg::IMG_W_BITS-1:0] img_w_q;
	logic [rgbc_pkg::HALF_BITS-1:0]  half_q;
	logic [rgbc_pkg::KROW_BITS-1:0]  krow_q [KR];
	logic [CW-1:0]                   w_eff;
	logic [rgbc_pkg::HALF_BITS-1:0]  d_eff;
	logic [rgbc_pkg::HALF_BITS:0]    d2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			img_w_q <= rgbc_pkg::IMG_W_BITS'(rgbc_pkg::IMG_W_RESET);
			half_q  <= rgbc_pkg::HALF_BITS'(rgbc_pkg::HALF_RESET);
			for (int i = 0; i < KR; i++)
				krow_q[i] <= '0;
		end else if (wr_en) begin
			if (wr_index == rgbc_pkg::REG_IMAGE_WIDTH)
				img_w_q <= wr_data[rgbc_pkg::IMG_W_BITS-1:0];
			else if (wr_index == rgbc_pkg::REG_HALF_WIDTH)
				half_q <= wr_data[rgbc_pkg::HALF_BITS-1:0];
			else if (wr_index >= rgbc_pkg::REG_KROW0 &&
			         int'(wr_index) < int'(rgbc_pkg::REG_KROW0) + KR)
				krow_q[wr_index - rgbc_pkg::REG_KROW0] <= wr_data[rgbc_pkg::KROW_BITS-1:0];
		end
	end

	always_comb begin
		if (img_w_q == '0)
			w_eff = CW'(1);
		else if (int'(img_w_q) > MAX_WIDTH)
			w_eff = CW'(MAX_WIDTH);
		else
			w_eff = CW'(img_w_q);
		d_eff = (int'(half_q) > rgbc_pkg::MAX_HALF) ?
		        rgbc_pkg::HALF_BITS'(rgbc_pkg::MAX_HALF) : half_q;
		d2    = {d_eff, 1'b0};
	end

	// position counters, handshake
	logic          acc;
	logic [FCW-1:0] inflight_q;
	logic [CW-1:0] col_q, col_a, c, c1;
	logic [RB-1:0] row_q, row_a, r;
	logic          pv, bd;

	assign pix_ready = int'(inflight_q) < FD;
	assign acc       = pix_valid && pix_ready;

	always_comb begin
		col_a = pix.frame_start ? '0 : col_q;
		row_a = pix.frame_start ? '0 : row_q;
		if (col_a >= w_eff) begin
			c = '0;
			r = (int'(row_a) < rgbc_pkg::ROW_MAX) ? RB'(row_a + 1'b1) : row_a;
		end else begin
			c = col_a;
			r = row_a;
		end
		c1 = c + 1'b1;
		pv = (r >= RB'(d_eff)) && (c >= CW'(d_eff));
		bd = (r < RB'(d2)) || (c < CW'(d2));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (acc) begin
			if (c1 >= w_eff) begin
				col_q <= '0;
				row_q <= (int'(r) < rgbc_pkg::ROW_MAX) ? RB'(r + 1'b1) : r;
			end else begin
				col_q <= c1;
				row_q <= r;
			end
		end
	end

	// stage 1: line store read data, write back shifted column
	logic            s1_vld_q, s2_vld_q, s3_vld_q, s4_vld_q;
	logic [CW-1:0]   c_s1;
	logic [PXB-1:0]  pix_s1;
	logic            pv_s1, bd_s1, pv_s2, bd_s2, pv_s3, bd_s3, pv_s4, bd_s4;
	logic            fwd_s1;
	logic [LW-1:0]   fwd_data_s1;
	logic [LW-1:0]   rdata, ld, wdata;
	logic [PXB-1:0]  col_in [KR];

	assign ld    = fwd_s1 ? fwd_data_s1 : rdata;
	assign wdata = {ld[LW-PXB-1:0], pix_s1};

	always_comb begin
		col_in[0] = pix_s1;
		for (int k = 0; k < rgbc_pkg::LINES; k++)
			col_in[k+1] = ld[k*PXB +: PXB];
	end

	rgbc_ram #(.WIDTH(LW), .DEPTH(MAX_WIDTH)) u_lines (
		.clk   (clk),
		.we    (s1_vld_q),
		.waddr (c_s1[AW-1:0]),
		.wdata (wdata),
		.re    (acc),
		.raddr (c[AW-1:0]),
		.rdata (rdata)
	);

	always_ff @(posedge clk) begin
		if (acc) begin
			c_s1        <= c;
			pix_s1      <= {pix.red_in, pix.green_in, pix.blue_in};
			pv_s1       <= pv;
			bd_s1       <= bd;
			fwd_s1      <= s1_vld_q && (c_s1 == c);
			fwd_data_s1 <= wdata;
		end
		pv_s2 <= pv_s1;
		bd_s2 <= bd_s1;
		pv_s3 <= pv_s2;
		bd_s3 <= bd_s2;
		pv_s4 <= pv_s3;
		bd_s4 <= bd_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_vld_q <= 1'b0;
			s2_vld_q <= 1'b0;
			s3_vld_q <= 1'b0;
			s4_vld_q <= 1'b0;
		end else begin
			s1_vld_q <= acc;
			s2_vld_q <= s1_vld_q;
			s3_vld_q <= s2_vld_q;
			s4_vld_q <= s3_vld_q;
		end
	end

	// window cells: row a shifts right, products registered
	logic [PXB-1:0]        win  [KR][KR];
	logic signed [PW-1:0]  prod [KR][KR][3];

	for (genvar a = 0; a < KR; a++) begin : g_row
		logic [63:0] row64;
		assign row64 = 64'(krow_q[a]);
		for (genvar b = 0; b < KR; b++) begin : g_col
			localparam int LO = COEF_BITS * b;
			logic signed [COEF_BITS-1:0] k;
			if (LO + COEF_BITS <= 64) begin : g_k
				assign k = row64[LO +: COEF_BITS];
			end else begin : g_kz
				assign k = '0;
			end
			rgbc_cell #(.COEF_BITS(COEF_BITS)) u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.shift_en (s1_vld_q),
				.pix_in   ((b == 0) ? col_in[a] : win[a][(b == 0) ? 0 : b-1]),
				.coef     (k),
				.use_coef ((rgbc_pkg::HALF_BITS+1)'(a) <= d2 &&
				           (rgbc_pkg::HALF_BITS+1)'(b) <= d2),
				.pix_q    (win[a][b]),
				.prod_s3  (prod[a][b])
			);
		end
	end

	// stage 4: row sums
	logic signed [RW-1:0] rsum_s4 [KR][3];

	always_ff @(posedge clk) begin
		for (int a = 0; a < KR; a++)
			for (int ch = 0; ch < 3; ch++)
				rsum_s4[a][ch] <= RW'(prod[a][0][ch]) + RW'(prod[a][1][ch]) +
				                  RW'(prod[a][2][ch]) + RW'(prod[a][3][ch]) +
				                  RW'(prod[a][4][ch]);
	end

	// final sum, clamp, border and queue
	logic signed [SW-1:0] tot [3];
	logic [CHB-1:0]       cl  [3];
	rgbc_pkg::res_t       res_d;

	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			tot[ch] = SW'(rsum_s4[0][ch]) + SW'(rsum_s4[1][ch]) + SW'(rsum_s4[2][ch]) +
			          SW'(rsum_s4[3][ch]) + SW'(rsum_s4[4][ch]);
			if (tot[ch][SW-1])
				cl[ch] = '0;
			else if (tot[ch] > SW'(255))
				cl[ch] = '1;
			else
				cl[ch] = tot[ch][CHB-1:0];
		end
		res_d = '0;
		if (pv_s4) begin
			res_d.position_valid = 1'b1;
			if (bd_s4) begin
				res_d.is_border = 1'b1;
				res_d.blue_out  = '1;
				res_d.green_out = '1;
				res_d.red_out   = '1;
			end else begin
				res_d.blue_out  = cl[0];
				res_d.green_out = cl[1];
				res_d.red_out   = cl[2];
			end
		end
	end

	logic           rd;
	logic [FCW-1:0] fcnt;

	assign rd = res_valid && res_ready;

	rgbc_fifo #(.DEPTH(FD)) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr        (s4_vld_q),
		.wdata     (res_d),
		.rd        (rd),
		.rdata     (res),
		.not_empty (res_valid),
		.cnt_q     (fcnt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			inflight_q <= '0;
		else
			inflight_q <= inflight_q + (acc ? 1'b1 : 1'b0) - (rd ? 1'b1 : 1'b0);
	end

	// checks
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(s4_vld_q && int'(fcnt) == FD && !rd))
		else $error("result queue overflow");

	a_occupancy: assert property (@(posedge clk) disable iff (!arst_n)
		int'(inflight_q) == $countones({s1_vld_q, s2_vld_q, s3_vld_q, s4_vld_q}) + int'(fcnt))
		else $error("in-flight count mismatch");

	a_fwd_only_valid: assert property (@(posedge clk) disable iff (!arst_n)
		acc && !s1_vld_q |=> !fwd_s1)
		else $error("forwarding without a preceding write");

endmodule

FILE: dv/testbench.sv
// Self-checking testbench of the streaming RGB convolution block.
module testbench;
	import rgbc_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic pix_valid = 1'b0;
	logic pix_ready;
	pix_t pix = '0;
	logic res_valid;
	logic res_ready = 1'b0;
	res_t res;
	logic wr_en = 1'b0;
	logic [CFG_IDX_BITS-1:0] wr_index = '0;
	logic [CFG_DATA_BITS-1:0] wr_data = '0;

	always #6 clk = ~clk;

	rgb_image_convolution dut (
		.clk(clk), .arst_n(arst_n),
		.pix_valid(pix_valid), .pix_ready(pix_ready), .pix(pix),
		.res_valid(res_valid), .res_ready(res_ready), .res(res),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
	);

	// shadow of the block: configuration and state
	logic [IMG_W_BITS-1:0] sh_width = IMG_W_BITS'(IMG_W_RESET);
	logic [HALF_BITS-1:0] sh_half = HALF_BITS'(HALF_RESET);
	logic [KROW_BITS-1:0] sh_krow [KROWS];
	logic [PIX_BITS-1:0] sh_lines [LINES][MAX_WIDTH_DEF];
	logic [PIX_BITS-1:0] sh_win [KROWS][KROWS];
	int unsigned sh_col = 0;
	int unsigned sh_row = 0;

	res_t expected_res [$];
	int errors = 0;
	bit idle_on = 1'b1;
	bit quiet = 1'b0;
	int hold_cnt = 0;
	int rx_stall = 0;

	initial begin
		foreach (sh_krow[i]) sh_krow[i] = '0;
		foreach (sh_win[i, j]) sh_win[i][j] = '0;
		foreach (sh_lines[i, j]) sh_lines[i][j] = '0;
	end

	function automatic int coef_of(int a, int b);
		logic signed [COEF_BITS_DEF-1:0] cv;
		cv = sh_krow[a][COEF_BITS_DEF*b +: COEF_BITS_DEF];
		return int'(cv);
	endfunction

	function automatic res_t convolve_pixel(pix_t p);
		res_t o;
		logic [PIX_BITS-1:0] px;
		logic [PIX_BITS-1:0] column [KROWS];
		int unsigned w, d, r, c;
		int s;
		o = '0;
		px = {p.red_in, p.green_in, p.blue_in};
		w = sh_width;
		d = sh_half;
		if (d > MAX_HALF) d = MAX_HALF;
		if (w == 0) w = 1;
		if (w > MAX_WIDTH_DEF) w = MAX_WIDTH_DEF;
		if (p.frame_start) begin
			sh_col = 0;
			sh_row = 0;
		end
		if (sh_col >= w) begin
			sh_col = 0;
			if (sh_row < ROW_MAX) sh_row++;
		end
		r = sh_row;
		c = sh_col;
		column[0] = px;
		for (int k = 0; k < LINES; k++) column[k+1] = sh_lines[k][c];
		for (int k = LINES - 1; k > 0; k--) sh_lines[k][c] = sh_lines[k-1][c];
		sh_lines[0][c] = px;
		for (int a = 0; a < KROWS; a++) begin
			for (int b = KROWS - 1; b > 0; b--) sh_win[a][b] = sh_win[a][b-1];
			sh_win[a][0] = column[a];
		end
		if (r >= d && c >= d) begin
			o.position_valid = 1'b1;
			if (r - d < d || c - d < d) begin
				o.blue_out = 8'hff;
				o.green_out = 8'hff;
				o.red_out = 8'hff;
				o.is_border = 1'b1;
			end else begin
				for (int ch = 0; ch < 3; ch++) begin
					s = 0;
					for (int a = 0; a <= 2 * d; a++)
						for (int b = 0; b <= 2 * d; b++)
							s += (coef_of(a, b) * int'(sh_win[a][b][8*ch +: 8])) / 256;
					if (s > 255) s = 255;
					if (s < 0) s = 0;
					case (ch)
						0: o.blue_out = s[7:0];
						1: o.green_out = s[7:0];
						default: o.red_out = s[7:0];
					endcase
				end
			end
		end
		sh_col = c + 1;
		if (sh_col >= w) begin
			sh_col = 0;
			if (sh_row < ROW_MAX) sh_row++;
		end
		return o;
	endfunction

	task automatic send_pixel(pix_t p);
		int gap;
		pix <= p;
		pix_valid <= 1'b1;
		do @(posedge clk); while (!pix_ready);
		expected_res.push_back(convolve_pixel(p));
		if (idle_on && !quiet && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 15);
			pix_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		pix_valid <= 1'b0;
		while (expected_res.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
		drain();
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(posedge clk);
		wr_en <= 1'b0;
		case (idx)
			REG_IMAGE_WIDTH: sh_width = val[IMG_W_BITS-1:0];
			REG_HALF_WIDTH: sh_half = val[HALF_BITS-1:0];
			default: sh_krow[idx - REG_KROW0] = val[KROW_BITS-1:0];
		endcase
	endtask

	function automatic pix_t rand_pixel(bit fs);
		pix_t p;
		p = pix_t'($urandom);
		if ($urandom_range(0, 9) == 0) p.red_in = $urandom_range(0, 1) ? 8'hff : 8'h00;
		if ($urandom_range(0, 9) == 0) p.blue_in = $urandom_range(0, 1) ? 8'hff : 8'h00;
		p.frame_start = fs;
		return p;
	endfunction

	function automatic logic [KROW_BITS-1:0] rand_krow();
		logic [KROW_BITS-1:0] v;
		v = KROW_BITS'({$urandom, $urandom});
		if ($urandom_range(0, 2) != 0)
			for (int b = 0; b < KROWS; b++)
				v[COEF_BITS_DEF*b +: COEF_BITS_DEF] = 12'($urandom_range(0, 160)) - 12'd64;
		return v;
	endfunction

	task automatic load_kernel_random();
		for (int a = 0; a < KROWS; a++)
			write_reg(CFG_IDX_BITS'(REG_KROW0 + a), rand_krow());
	endtask

	task automatic load_kernel_flat(logic [COEF_BITS_DEF-1:0] cv);
		for (int a = 0; a < KROWS; a++)
			write_reg(CFG_IDX_BITS'(REG_KROW0 + a), {KROWS{cv}});
	endtask

	// frame of given size; noise may add stray frame starts
	task automatic send_frame(int rows, int cols, bit noise);
		for (int i = 0; i < rows * cols; i++)
			send_pixel(rand_pixel(i == 0 || (noise && $urandom_range(0, 40) == 0)));
	endtask

	task automatic test_reset_state();
		for (int i = 0; i < 6; i++) send_pixel(rand_pixel(i == 0));
	endtask

	task automatic test_identity_kernel();
		pix_t p;
		write_reg(REG_IMAGE_WIDTH, CFG_DATA_BITS'(5));
		write_reg(REG_HALF_WIDTH, CFG_DATA_BITS'(1));
		load_kernel_flat(12'h000);
		write_reg(CFG_IDX_BITS'(REG_KROW0 + 1), 60'd256 << COEF_BITS_DEF);
		for (int i = 0; i < 20; i++) begin
			p = rand_pixel(i == 0);
			if (i % 3 == 0) {p.blue_in, p.green_in, p.red_in} = '1;
			if (i % 3 == 1) {p.blue_in, p.green_in, p.red_in} = '0;
			send_pixel(p);
		end
	endtask

	task automatic test_extreme_coefs();
		write_reg(REG_IMAGE_WIDTH, CFG_DATA_BITS'(3));
		load_kernel_flat(12'h800);
		send_frame(3, 3, 0);
		load_kernel_flat(12'h7ff);
		send_frame(3, 3, 0);
	endtask

	task automatic test_half_widths();
		load_kernel_random();
		for (int h = 0; h < 4; h++) begin
			write_reg(REG_HALF_WIDTH, CFG_DATA_BITS'(h));
			send_frame(6, 7, 0);
		end
	endtask

	task automatic test_width_limits();
		write_reg(REG_HALF_WIDTH, CFG_DATA_BITS'(0));
		write_reg(REG_IMAGE_WIDTH, CFG_DATA_BITS'(0));
		send_frame(4, 1, 0);
		write_reg(REG_HALF_WIDTH, CFG_DATA_BITS'(2));
		write_reg(REG_IMAGE_WIDTH, CFG_DATA_BITS'(12'hfff));
		send_frame(1, 12, 0);
		write_reg(REG_IMAGE_WIDTH, CFG_DATA_BITS'(MAX_WIDTH_DEF));
		send_frame(1, 8, 0);
	endtask

	task automatic test_width_shrink();
		write_reg(REG_HALF_WIDTH, CFG_DATA_BITS'(1));
		write_reg(REG_IMAGE_WIDTH, CFG_DATA_BITS'(8));
		send_frame(1, 29, 0);
		write_reg(REG_IMAGE_WIDTH, CFG_DATA_BITS'(4));
		for (int i = 0; i < 14; i++) send_pixel(rand_pixel(0));
	endtask

	task automatic test_row_saturation();
		write_reg(REG_HALF_WIDTH, CFG_DATA_BITS'(0));
		write_reg(REG_IMAGE_WIDTH, CFG_DATA_BITS'(1));
		idle_on = 1'b0;
		send_frame(ROW_MAX + 6, 1, 0);
		idle_on = 1'b1;
	endtask

	task automatic test_backpressure();
		write_reg(REG_HALF_WIDTH, CFG_DATA_BITS'(1));
		write_reg(REG_IMAGE_WIDTH, CFG_DATA_BITS'(6));
		hold_cnt = 60;
		send_frame(5, 6, 0);
	endtask

	task automatic test_random_frames(int n_items);
		int sent, w, rows;
		sent = 0;
		while (sent < n_items) begin
			w = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
			rows = $urandom_range(1, 8);
			write_reg(REG_IMAGE_WIDTH, CFG_DATA_BITS'(w));
			write_reg(REG_HALF_WIDTH, CFG_DATA_BITS'($urandom_range(0, 3)));
			if ($urandom_range(0, 1)) load_kernel_random();
			if (sent > n_items * 3 / 4) quiet = 1'b1;
			send_frame(rows, w, $urandom_range(0, 4) == 0);
			sent += rows * w;
		end
	endtask

	always @(posedge clk) begin
		res_t exp_r;
		if (res_valid && res_ready) begin
			if (expected_res.size() == 0) begin
				$display("%0t unexpected result %h", $time, res);
				errors++;
			end else begin
				exp_r = expected_res.pop_front();
				if (res.blue_out !== exp_r.blue_out || res.green_out !== exp_r.green_out
						|| res.red_out !== exp_r.red_out
						|| res.position_valid !== exp_r.position_valid
						|| res.is_border !== exp_r.is_border) begin
					$display("%0t mismatch exp b%h g%h r%h v%b e%b got b%h g%h r%h v%b e%b",
						$time, exp_r.blue_out, exp_r.green_out, exp_r.red_out,
						exp_r.position_valid, exp_r.is_border, res.blue_out, res.green_out,
						res.red_out, res.position_valid, res.is_border);
					errors++;
				end
			end
		end
		if (hold_cnt > 0) begin
			hold_cnt--;
			res_ready <= 1'b0;
		end else if (quiet || !idle_on) begin
			res_ready <= 1'b1;
		end else if (rx_stall > 0) begin
			rx_stall--;
			res_ready <= 1'b0;
		end else if ($urandom_range(0, 7) == 0) begin
			rx_stall = $urandom_range(0, 14);
			res_ready <= 1'b0;
		end else begin
			res_ready <= 1'b1;
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_identity_kernel();
		test_extreme_coefs();
		test_half_widths();
		test_width_limits();
		test_width_shrink();
		test_row_saturation();
		test_backpressure();
		test_random_frames(800);
		drain();
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#(12 * 400000);
		$display("TEST FAILED");
		$finish;
	end

endmodule
